[design/kddw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kddw_pkg
// shared widths, result kinds and state encodings for the dash/dot unranker
// ----------------------------------------------------------------------------
package kddw_pkg;

  localparam int CNT_W  = 7;
  localparam int RANK_W = 30;
  localparam int VAL_W  = 30;

  localparam logic [VAL_W-1:0] SAT_CAP = 30'd1000000100;

  typedef enum logic [1:0] {
    KIND_SYMBOL    = 2'd0,
    KIND_EMPTY     = 2'd1,
    KIND_BEYOND    = 2'd2,
    KIND_TOO_LARGE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    WALK_IDLE,
    WALK_CHECK,
    WALK_STEP
  } walk_state_t;

  typedef enum logic {
    BLD_FILL,
    BLD_DONE
  } bld_state_t;

endpackage

[design/kddw_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kddw_table
// binomial table memory, one write port and two registered read ports
// ----------------------------------------------------------------------------
module kddw_table #(
  parameter int MAX_TOTAL = 64
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [$clog2((MAX_TOTAL+1)**2)-1:0] waddr,
  input  logic [kddw_pkg::VAL_W-1:0]          wdata,
  input  logic [$clog2((MAX_TOTAL+1)**2)-1:0] raddr_a,
  input  logic [$clog2((MAX_TOTAL+1)**2)-1:0] raddr_b,
  output logic [kddw_pkg::VAL_W-1:0]          rdata_a,
  output logic [kddw_pkg::VAL_W-1:0]          rdata_b
);

  localparam int DEPTH = (MAX_TOTAL + 1) * (MAX_TOTAL + 1);

  logic [kddw_pkg::VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[design/kddw_build.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kddw_build
// fills the table with a capped pascal triangle, one entry per cycle, row by
// row, reading the entry above from the previous row
// ----------------------------------------------------------------------------
module kddw_build #(
  parameter int MAX_TOTAL = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [kddw_pkg::VAL_W-1:0]          rdata,
  output logic [$clog2((MAX_TOTAL+1)**2)-1:0] raddr,
  output logic                                we,
  output logic [$clog2((MAX_TOTAL+1)**2)-1:0] waddr,
  output logic [kddw_pkg::VAL_W-1:0]          wdata,
  output logic                                done
);

  localparam int DIM   = MAX_TOTAL + 1;
  localparam int DEPTH = DIM * DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_TOTAL + 1);

  kddw_pkg::bld_state_t state, state_next;

  logic [CW-1:0]              row;
  logic [CW-1:0]              col;
  logic [AW-1:0]              addr;
  logic                       issue;
  logic                       last_issue;
  logic                       wr_valid;
  logic [AW-1:0]              wr_addr;
  logic                       wr_row0;
  logic                       wr_col0;
  logic [kddw_pkg::VAL_W-1:0] prev;
  logic [kddw_pkg::VAL_W:0]   sum;

  assign last_issue = (row == CW'(MAX_TOTAL)) && (col == CW'(MAX_TOTAL));

  always_comb begin
    state_next = state;
    case (state)
      kddw_pkg::BLD_FILL: if (last_issue) state_next = kddw_pkg::BLD_DONE;
      kddw_pkg::BLD_DONE: state_next = kddw_pkg::BLD_DONE;
      default:            state_next = kddw_pkg::BLD_FILL;
    endcase
  end

  always_comb begin
    issue = (state == kddw_pkg::BLD_FILL);
    raddr = (row == '0) ? '0 : addr - AW'(DIM);
    done  = (state == kddw_pkg::BLD_DONE) && !wr_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= kddw_pkg::BLD_FILL;
      row      <= '0;
      col      <= '0;
      addr     <= '0;
      wr_valid <= 1'b0;
    end else begin
      state    <= state_next;
      wr_valid <= issue;
      if (issue) begin
        addr <= addr + AW'(1);
        if (col == CW'(MAX_TOTAL)) begin
          col <= '0;
          row <= row + CW'(1);
        end else begin
          col <= col + CW'(1);
        end
      end
    end
  end

  // write stage, entry above-left comes from the previous read
  always_ff @(posedge clk) begin
    wr_addr <= addr;
    wr_row0 <= (row == '0);
    wr_col0 <= (col == '0);
    if (wr_valid) begin
      prev <= rdata;
    end
  end

  always_comb begin
    sum = {1'b0, (wr_col0 ? '0 : prev)} + {1'b0, rdata};
    we    = wr_valid;
    waddr = wr_addr;
    if (wr_row0) begin
      wdata = wr_col0 ? kddw_pkg::VAL_W'(1) : '0;
    end else if (sum > {1'b0, kddw_pkg::SAT_CAP}) begin
      wdata = kddw_pkg::SAT_CAP;
    end else begin
      wdata = sum[kddw_pkg::VAL_W-1:0];
    end
  end

endmodule

[design/kddw_walk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kddw_walk
// query sequencer: checks the counts and rank, then emits one symbol per cycle
// unless the output stalls, prefetching table entries for both possible next symbols
// ----------------------------------------------------------------------------
module kddw_walk #(
  parameter int MAX_TOTAL = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                built,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [kddw_pkg::CNT_W-1:0]          dash_count,
  input  logic [kddw_pkg::CNT_W-1:0]          dot_count,
  input  logic [kddw_pkg::RANK_W-1:0]         rank,
  output logic [$clog2((MAX_TOTAL+1)**2)-1:0] raddr_a,
  output logic [$clog2((MAX_TOTAL+1)**2)-1:0] raddr_b,
  input  logic [kddw_pkg::VAL_W-1:0]          rdata_a,
  input  logic [kddw_pkg::VAL_W-1:0]          rdata_b,
  output logic                                out_valid,
  input  logic                                out_ready,
  output kddw_pkg::kind_t                     kind,
  output logic                                symbol,
  output logic                                last
);

  localparam int DIM = MAX_TOTAL + 1;
  localparam int AW  = $clog2(DIM * DIM);
  localparam int TW  = kddw_pkg::CNT_W + 1;

  function automatic logic [AW-1:0] addr_of(input logic [TW-1:0] t, input logic [TW-1:0] k);
    return AW'(t) * AW'(DIM) + AW'(k);
  endfunction

  kddw_pkg::walk_state_t state, state_next;

  logic [kddw_pkg::CNT_W-1:0]  a;
  logic [kddw_pkg::CNT_W-1:0]  b;
  logic [kddw_pkg::RANK_W-1:0] r;
  logic                        sel;
  logic [AW-1:0]               addr_a_q;
  logic [AW-1:0]               addr_b_q;

  logic                        can_load;
  logic                        accept;
  logic [TW-1:0]               in_total;
  logic                        too_large;
  logic                        empty;
  logic                        beyond;
  logic [TW-1:0]               cur_total;
  logic [kddw_pkg::VAL_W-1:0]  cur_c;
  logic                        step_dash;
  logic [kddw_pkg::CNT_W-1:0]  a_new;
  logic [kddw_pkg::CNT_W-1:0]  b_new;
  logic [kddw_pkg::RANK_W-1:0] r_new;
  logic                        step_last;
  logic                        load;
  kddw_pkg::kind_t             load_kind;
  logic                        load_sym;
  logic                        load_last;

  assign can_load  = !out_valid || out_ready;
  assign in_ready  = (state == kddw_pkg::WALK_IDLE) && built && can_load;
  assign accept    = in_valid && in_ready;
  assign in_total  = TW'(dash_count) + TW'(dot_count);
  assign too_large = in_total > TW'(MAX_TOTAL);
  assign empty     = (in_total == '0);
  assign beyond    = (r >= rdata_a);
  assign cur_total = TW'(a) + TW'(b);

  always_comb begin
    state_next = state;
    case (state)
      kddw_pkg::WALK_IDLE: begin
        if (accept && !too_large && !empty) state_next = kddw_pkg::WALK_CHECK;
      end
      kddw_pkg::WALK_CHECK: begin
        if (!beyond) state_next = kddw_pkg::WALK_STEP;
        else if (can_load) state_next = kddw_pkg::WALK_IDLE;
      end
      kddw_pkg::WALK_STEP: begin
        if (can_load && step_last) state_next = kddw_pkg::WALK_IDLE;
      end
      default: state_next = kddw_pkg::WALK_IDLE;
    endcase
  end

  // one step of the walk
  always_comb begin
    cur_c     = sel ? rdata_b : rdata_a;
    step_dash = (a != '0) && (r < cur_c);
    a_new     = step_dash ? a - kddw_pkg::CNT_W'(1) : a;
    b_new     = step_dash ? b : b - kddw_pkg::CNT_W'(1);
    r_new     = (a != '0 && !step_dash) ? r - cur_c : r;
    step_last = (TW'(a_new) + TW'(b_new) == '0);
  end

  // table reads, held while stalled so the data is there again next cycle
  always_comb begin
    raddr_a = addr_a_q;
    raddr_b = addr_b_q;
    case (state)
      kddw_pkg::WALK_IDLE: begin
        raddr_a = too_large ? '0 : addr_of(in_total, TW'(dash_count));
        raddr_b = (dash_count == '0 || too_large) ? '0 :
                  addr_of(in_total - TW'(1), TW'(dash_count) - TW'(1));
      end
      kddw_pkg::WALK_STEP: begin
        if (can_load) begin
          raddr_a = (a < kddw_pkg::CNT_W'(2)) ? '0 :
                    addr_of(cur_total - TW'(2), TW'(a) - TW'(2));
          raddr_b = (a == '0 || cur_total < TW'(2)) ? '0 :
                    addr_of(cur_total - TW'(2), TW'(a) - TW'(1));
        end
      end
      default: begin
        raddr_a = addr_a_q;
        raddr_b = addr_b_q;
      end
    endcase
  end

  always_comb begin
    load      = 1'b0;
    load_kind = kddw_pkg::KIND_SYMBOL;
    load_sym  = 1'b0;
    load_last = 1'b1;
    case (state)
      kddw_pkg::WALK_IDLE: begin
        if (accept && too_large) begin
          load      = 1'b1;
          load_kind = kddw_pkg::KIND_TOO_LARGE;
        end else if (accept && empty) begin
          load      = 1'b1;
          load_kind = kddw_pkg::KIND_EMPTY;
        end
      end
      kddw_pkg::WALK_CHECK: begin
        if (beyond) begin
          load      = 1'b1;
          load_kind = kddw_pkg::KIND_BEYOND;
        end
      end
      kddw_pkg::WALK_STEP: begin
        load      = 1'b1;
        load_sym  = !step_dash;
        load_last = step_last;
      end
      default: load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kddw_pkg::WALK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (can_load) begin
        out_valid <= load;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_a_q <= raddr_a;
    addr_b_q <= raddr_b;
    if (accept) begin
      a <= dash_count;
      b <= dot_count;
      r <= rank;
    end
    if (state == kddw_pkg::WALK_CHECK) begin
      sel <= 1'b1;
    end
    if (state == kddw_pkg::WALK_STEP && can_load) begin
      a   <= a_new;
      b   <= b_new;
      r   <= r_new;
      sel <= !step_dash;
    end
    if (can_load && load) begin
      kind   <= load_kind;
      symbol <= load_sym;
      last   <= load_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_step_has_symbols: assert property (@(posedge clk) disable iff (rst)
    (state == kddw_pkg::WALK_STEP) |-> (cur_total != '0))
    else $error("walk step with no symbols left");

  a_too_large_flag: assert property (@(posedge clk) disable iff (rst)
    (accept && too_large) |=>
      (out_valid && kind == kddw_pkg::KIND_TOO_LARGE && last))
    else $error("oversized counts not flagged");

  a_dots_only: assert property (@(posedge clk) disable iff (rst)
    (state == kddw_pkg::WALK_STEP && can_load && a == '0) |=> (out_valid && symbol))
    else $error("dash emitted with no dashes left");

  a_ready_after_build: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> built)
    else $error("query taken before table is built");
`endif

endmodule

[design/kth_dash_dot_word_unrank_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kth_dash_dot_word_unrank_top
// returns the word of a given rank among all words with fixed dash and dot
// counts, one symbol per output word
// ----------------------------------------------------------------------------
// s_* carries one query: dash count, dot count and zero-based rank. m_* gives
// the answer, one word per symbol (kind 0 on m_tuser, dash 0 / dot 1 on
// m_tdata) with tlast on the final symbol, or a single flagged word with
// tlast for an empty word, a rank beyond the capped count, or counts whose
// sum exceeds MAX_TOTAL.
// after rst all (MAX_TOTAL+1)^2 binomial table entries are built, one entry per
// cycle through the table write port; s_tready stays low during that pass.
// a query of n symbols runs accept, rank check, then one symbol per cycle unless
// the output stalls: the walk does one table lookup, compare and subtract
// per symbol, with both candidate entries for the next symbol read ahead on
// the two read ports. flagged queries end at accept or at the rank check.
// the output is a single register; while m_tready is low the walk holds and
// re-reads the same entries, and s_tready is low until the query is done.
// ----------------------------------------------------------------------------
module kth_dash_dot_word_unrank_top #(
  parameter int MAX_TOTAL = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // dash_count[6:0], dot_count[13:7], rank[43:14]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // symbol[0]
  output logic [1:0]  m_tuser,   // kind[1:0]
  output logic        m_tlast
);

  localparam int AW = $clog2((MAX_TOTAL + 1) * (MAX_TOTAL + 1));

  logic [AW-1:0]              bld_raddr;
  logic                       bld_we;
  logic [AW-1:0]              bld_waddr;
  logic [kddw_pkg::VAL_W-1:0] bld_wdata;
  logic                       built;
  logic [AW-1:0]              walk_raddr_a;
  logic [AW-1:0]              walk_raddr_b;
  logic [AW-1:0]              tbl_raddr_a;
  logic [kddw_pkg::VAL_W-1:0] tbl_rdata_a;
  logic [kddw_pkg::VAL_W-1:0] tbl_rdata_b;
  kddw_pkg::kind_t            out_kind;
  logic                       out_symbol;

  assign tbl_raddr_a = built ? walk_raddr_a : bld_raddr;

  kddw_table #(.MAX_TOTAL(MAX_TOTAL)) u_table (
    .clk     (clk),
    .we      (bld_we),
    .waddr   (bld_waddr),
    .wdata   (bld_wdata),
    .raddr_a (tbl_raddr_a),
    .raddr_b (walk_raddr_b),
    .rdata_a (tbl_rdata_a),
    .rdata_b (tbl_rdata_b)
  );

  kddw_build #(.MAX_TOTAL(MAX_TOTAL)) u_build (
    .clk   (clk),
    .rst   (rst),
    .rdata (tbl_rdata_a),
    .raddr (bld_raddr),
    .we    (bld_we),
    .waddr (bld_waddr),
    .wdata (bld_wdata),
    .done  (built)
  );

  kddw_walk #(.MAX_TOTAL(MAX_TOTAL)) u_walk (
    .clk        (clk),
    .rst        (rst),
    .built      (built),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .dash_count (s_tdata[6:0]),
    .dot_count  (s_tdata[13:7]),
    .rank       (s_tdata[43:14]),
    .raddr_a    (walk_raddr_a),
    .raddr_b    (walk_raddr_b),
    .rdata_a    (tbl_rdata_a),
    .rdata_b    (tbl_rdata_b),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .kind       (out_kind),
    .symbol     (out_symbol),
    .last       (m_tlast)
  );

  assign m_tdata = {7'b0, out_symbol};
  assign m_tuser = out_kind;

endmodule
